@@ rtl/kmhrb_pkg.sv @@
`default_nettype none

package kmhrb_pkg;

    localparam int MATRIX_ROWS_DEF = 8;
    localparam int MATRIX_COLS_DEF = 8;
    localparam int KEY_SLOTS_DEF   = 6;
    localparam int MAX_SLOTS       = 6;

    localparam int KEY_W      = 6;
    localparam int LINE_W     = 3;
    localparam int LAYOUT_DEPTH = 64;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic OP_LAYOUT = 1'b0;
    localparam logic OP_SCAN   = 1'b1;

    localparam logic REG_FN_POS   = 1'b0;
    localparam logic REG_LOCK_POS = 1'b1;

    localparam logic [KEY_W-1:0] FN_POS_RESET   = 6'd63;
    localparam logic [KEY_W-1:0] LOCK_POS_RESET = 6'd23;

    typedef struct packed {
        logic        operation;
        logic [5:0]  key_index;
        logic [7:0]  base_code;
        logic [7:0]  layer_code;
        logic [7:0]  base_word;
        logic [7:0]  layer_word;
        logic [63:0] matrix_levels;
    } t_in_item;

    typedef struct packed {
        logic [7:0] modifier_byte;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } t_out_item;

    typedef struct packed {
        logic [7:0] layer_word;
        logic [7:0] base_word;
        logic [7:0] layer_code;
        logic [7:0] base_code;
    } t_layout_entry;

    typedef struct packed {
        logic       clear;
        logic       op_valid;
        logic       release_key;
        logic [7:0] code;
    } t_slot_ctl;

    typedef logic [MAX_SLOTS-1:0][7:0] t_slot_array;

endpackage

`default_nettype wire

@@ rtl/kmhrb_ram.sv @@
`default_nettype none

module kmhrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/kmhrb_slots.sv @@
`default_nettype none

module kmhrb_slots #(
    parameter int KEY_SLOTS = kmhrb_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire kmhrb_pkg::t_slot_ctl   i_ctl,
    output kmhrb_pkg::t_slot_array      o_slots
);

    logic [7:0] r_slot [KEY_SLOTS];
    logic [7:0] n_slot [KEY_SLOTS];
    logic       found;

    // first-match search: empty slot on press, equal code on release
    always_comb begin
        n_slot = r_slot;
        found  = 1'b0;
        if (i_ctl.clear) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                n_slot[i] = 8'h00;
            end
        end else if (i_ctl.op_valid) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (!found && (i_ctl.release_key ? (r_slot[i] == i_ctl.code)
                                                 : (r_slot[i] == 8'h00))) begin
                    n_slot[i] = i_ctl.release_key ? 8'h00 : i_ctl.code;
                    found     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slot[i] <= 8'h00;
            end
        end else begin
            r_slot <= n_slot;
        end
    end

    for (genvar g = 0; g < kmhrb_pkg::MAX_SLOTS; g++) begin : g_out
        if (g < KEY_SLOTS) begin : g_used
            assign o_slots[g] = r_slot[g];
        end else begin : g_unused
            assign o_slots[g] = 8'h00;
        end
    end

endmodule

`default_nettype wire

@@ rtl/keyboard_matrix_hid_report_builder.sv @@
// Boot keyboard report builder for a key matrix of up to 8x8 keys.
// Input channel (i_in_valid / o_in_stall) carries two kinds of request:
// a layout write, stored in a 64-entry table, and a matrix scan (bit
// row*8+col, 0 pressed). A scan is compared with the last one; while
// unlocked, changes update the modifier byte and six key slots, and when
// anything changed one report (boot report without its reserved byte, 7
// bytes) is put on the output channel (o_out_valid / i_out_stall).
// A scan walks the keys in passes: each key is read from the table (S_RD)
// and then handled (S_EX), with an extra step (S_EX2) for each ordinary
// key swapped on an FN edge. An FN edge adds a pass over all keys before
// the key pass; while locked only that FN pass runs, if any. Each key costs
// one table read; ordinary key changes use the shared slot search unit.
// The first scan after reset only records the matrix and sends nothing.
// The input stalls while a scan is in progress. A finished report sits in
// the output register; if the receiver still holds the previous one, the
// block waits there with the input stalled until it is taken.
// Reset clears the report, the FN and lock state and the saved matrix (all
// released); the layout table holds garbage until written.
// Config: APB registers fn key position at 0x0, lock key position at 0x4.
`default_nettype none

module keyboard_matrix_hid_report_builder #(
    parameter int MATRIX_ROWS      = kmhrb_pkg::MATRIX_ROWS_DEF,
    parameter int MATRIX_COLS      = kmhrb_pkg::MATRIX_COLS_DEF,
    parameter int REPORT_KEY_SLOTS = kmhrb_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire kmhrb_pkg::t_in_item                 i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output kmhrb_pkg::t_out_item                     o_out_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [kmhrb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [kmhrb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [kmhrb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_EX2  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic PH_FN  = 1'b0;
    localparam logic PH_KEY = 1'b1;

    localparam logic [kmhrb_pkg::LINE_W-1:0] ROW_LAST =
        kmhrb_pkg::LINE_W'(MATRIX_ROWS - 1);
    localparam logic [kmhrb_pkg::LINE_W-1:0] COL_LAST =
        kmhrb_pkg::LINE_W'(MATRIX_COLS - 1);

    logic [2:0]  r_state, n_state;
    logic        r_phase, n_phase;
    logic [kmhrb_pkg::LINE_W-1:0] r_row, n_row, r_col, n_col;
    logic [63:0] r_cur, n_cur, r_prev, n_prev;
    logic [7:0]  r_mod, n_mod;
    logic        r_fn_active, n_fn_active;
    logic        r_lock_active, n_lock_active;
    logic        r_started, n_started;
    logic        r_send, n_send;
    logic [kmhrb_pkg::KEY_W-1:0] r_fn_pos, r_lock_pos;

    logic                      r_out_valid;
    kmhrb_pkg::t_out_item      r_out;
    kmhrb_pkg::t_slot_array    slots;
    kmhrb_pkg::t_slot_ctl      slot_ctl;
    kmhrb_pkg::t_layout_entry  entry;
    logic [31:0]               ram_rdata;

    logic                      in_accept;
    logic                      cfg_write;
    logic                      out_load;
    logic                      advance;
    logic                      lock_down;
    logic                      fn_down;
    logic                      cur_bit;
    logic                      prev_bit;
    logic                      is_mod;
    logic [7:0]                sel_code;
    logic [kmhrb_pkg::KEY_W-1:0] key_idx;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign key_idx  = {r_row, r_col};
    assign entry    = kmhrb_pkg::t_layout_entry'(ram_rdata);
    assign is_mod   = (entry.base_code != entry.base_word);
    assign cur_bit  = r_cur[key_idx];
    assign prev_bit = r_prev[key_idx];
    assign sel_code = r_fn_active ? entry.layer_code : entry.base_code;
    assign lock_down = !i_in_data.matrix_levels[r_lock_pos];
    assign fn_down   = !i_in_data.matrix_levels[r_fn_pos];

    kmhrb_ram #(
        .WIDTH ($bits(kmhrb_pkg::t_layout_entry)),
        .DEPTH (kmhrb_pkg::LAYOUT_DEPTH)
    ) u_layout (
        .i_clk   (i_clk),
        .i_we    (in_accept && (i_in_data.operation == kmhrb_pkg::OP_LAYOUT)),
        .i_waddr (i_in_data.key_index),
        .i_wdata ({i_in_data.layer_word, i_in_data.base_word,
                   i_in_data.layer_code, i_in_data.base_code}),
        .i_raddr (key_idx),
        .o_rdata (ram_rdata)
    );

    kmhrb_slots #(
        .KEY_SLOTS (REPORT_KEY_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (slot_ctl),
        .o_slots (slots)
    );

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_row         = r_row;
        n_col         = r_col;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_mod         = r_mod;
        n_fn_active   = r_fn_active;
        n_lock_active = r_lock_active;
        n_started     = r_started;
        n_send        = r_send;
        slot_ctl      = '0;
        advance       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.operation == kmhrb_pkg::OP_SCAN)) begin
                    n_cur = i_in_data.matrix_levels;
                    if (!r_started) begin
                        n_prev    = i_in_data.matrix_levels;
                        n_started = 1'b1;
                    end else begin
                        n_send = 1'b0;
                        if (!r_lock_active && lock_down) begin
                            n_mod          = 8'h00;
                            slot_ctl.clear = 1'b1;
                            n_send         = 1'b1;
                        end
                        n_lock_active = lock_down;
                        n_fn_active   = fn_down;
                        n_row         = '0;
                        n_col         = '0;
                        if (fn_down != r_fn_active) begin
                            n_phase = PH_FN;
                            n_state = S_RD;
                        end else if (!lock_down) begin
                            n_phase = PH_KEY;
                            n_state = S_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                advance = 1'b1;
                if (r_phase == PH_FN) begin
                    // held key moves between layers on an fn edge
                    if (!prev_bit && !cur_bit && (entry.base_code != entry.layer_code)) begin
                        n_send = 1'b1;
                        if (is_mod) begin
                            n_mod = r_fn_active ? ((r_mod & ~entry.base_code) | entry.layer_code)
                                                : ((r_mod & ~entry.layer_code) | entry.base_code);
                        end else begin
                            slot_ctl.op_valid    = 1'b1;
                            slot_ctl.release_key = 1'b1;
                            slot_ctl.code        = r_fn_active ? entry.base_code
                                                               : entry.layer_word;
                            advance              = 1'b0;
                            n_state              = S_EX2;
                        end
                    end
                end else begin
                    if (prev_bit != cur_bit) begin
                        n_send = 1'b1;
                        if (is_mod) begin
                            n_mod = cur_bit ? (r_mod & ~sel_code) : (r_mod | sel_code);
                        end else begin
                            slot_ctl.op_valid    = 1'b1;
                            slot_ctl.release_key = cur_bit;
                            slot_ctl.code        = sel_code;
                        end
                    end
                end
            end
            S_EX2: begin
                slot_ctl.op_valid    = 1'b1;
                slot_ctl.release_key = 1'b0;
                slot_ctl.code        = r_fn_active ? entry.layer_word : entry.base_word;
                advance              = 1'b1;
            end
            S_OUT: begin
                n_prev = r_cur;
                if (!r_send || !r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (advance) begin
            n_state = S_RD;
            if (r_col == COL_LAST) begin
                n_col = '0;
                if (r_row == ROW_LAST) begin
                    n_row = '0;
                    if ((r_phase == PH_FN) && !r_lock_active) begin
                        n_phase = PH_KEY;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    assign out_load = (r_state == S_OUT) && r_send && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_FN;
            r_row         <= '0;
            r_col         <= '0;
            r_prev        <= '1;
            r_mod         <= 8'h00;
            r_fn_active   <= 1'b0;
            r_lock_active <= 1'b0;
            r_started     <= 1'b0;
            r_send        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_row         <= n_row;
            r_col         <= n_col;
            r_prev        <= n_prev;
            r_mod         <= n_mod;
            r_fn_active   <= n_fn_active;
            r_lock_active <= n_lock_active;
            r_started     <= n_started;
            r_send        <= n_send;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (out_load) begin
            r_out.modifier_byte <= r_mod;
            r_out.slot_zero     <= slots[0];
            r_out.slot_one      <= slots[1];
            r_out.slot_two      <= slots[2];
            r_out.slot_three    <= slots[3];
            r_out.slot_four     <= slots[4];
            r_out.slot_five     <= slots[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_pos   <= kmhrb_pkg::FN_POS_RESET;
            r_lock_pos <= kmhrb_pkg::LOCK_POS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == kmhrb_pkg::REG_LOCK_POS) begin
                r_lock_pos <= pwdata[kmhrb_pkg::KEY_W-1:0];
            end else begin
                r_fn_pos <= pwdata[kmhrb_pkg::KEY_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == kmhrb_pkg::REG_FN_POS)
                  ? kmhrb_pkg::CFG_DATA_W'(r_fn_pos)
                  : kmhrb_pkg::CFG_DATA_W'(r_lock_pos);

endmodule

`default_nettype wire

@@ dv/kmhrb_report_checker.sv @@
module kmhrb_report_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire kmhrb_pkg::t_in_item                 i_in_data,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire kmhrb_pkg::t_out_item                i_out_data,
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic [kmhrb_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  wire logic [kmhrb_pkg::CFG_DATA_W-1:0]    i_pwdata,
    input  wire logic                                i_pready,
    output int                                       o_mismatches,
    output int                                       o_outstanding,
    output int                                       o_reports
);
    import kmhrb_pkg::*;

    // shadow of the block state
    t_layout_entry     layout_tbl [LAYOUT_DEPTH];
    logic [63:0]       prev_levels;
    logic [7:0]        mod_state;
    logic [7:0]        slots [MAX_SLOTS];
    logic              fn_on;
    logic              lock_on;
    logic              seen_scan;
    logic [KEY_W-1:0]  fn_pos;
    logic [KEY_W-1:0]  lock_pos;

    t_out_item         expected_reports [$];

    task automatic slot_take(input logic [7:0] code);
        for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
            if (slots[i] == 8'd0) begin
                slots[i] = code;
                return;
            end
        end
    endtask

    task automatic slot_free(input logic [7:0] code);
        for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
            if (slots[i] == code) begin
                slots[i] = 8'd0;
                return;
            end
        end
    endtask

    task automatic predict_report(input t_in_item req);
        logic [63:0]   cur;
        logic [63:0]   prev;
        logic          send;
        logic          fn_press;
        logic          fn_release;
        logic          lock_down;
        logic          fn_down;
        logic          rel;
        logic [7:0]    code;
        t_layout_entry e;
        t_out_item     rpt;
        int            k;

        if (req.operation == OP_LAYOUT) begin
            layout_tbl[req.key_index] = '{layer_word: req.layer_word,
                                          base_word:  req.base_word,
                                          layer_code: req.layer_code,
                                          base_code:  req.base_code};
            return;
        end

        cur        = req.matrix_levels;
        prev       = prev_levels;
        send       = 1'b0;
        fn_press   = 1'b0;
        fn_release = 1'b0;

        if (seen_scan) begin
            lock_down = !cur[lock_pos];
            fn_down   = !cur[fn_pos];

            if (!lock_on && lock_down) begin
                mod_state = 8'd0;
                for (int i = 0; i < MAX_SLOTS; i++) slots[i] = 8'd0;
                send    = 1'b1;
                lock_on = 1'b1;
            end
            if (lock_on && !lock_down) lock_on = 1'b0;

            if (fn_down && !fn_on) begin
                fn_on    = 1'b1;
                fn_press = 1'b1;
            end else if (!fn_down && fn_on) begin
                fn_on      = 1'b0;
                fn_release = 1'b1;
            end

            // keys held across an fn edge move to the other layer
            if (fn_press || fn_release) begin
                for (int r = 0; r < MATRIX_ROWS_DEF; r++) begin
                    for (int c = 0; c < MATRIX_COLS_DEF; c++) begin
                        k = r * 8 + c;
                        e = layout_tbl[k];
                        if (!prev[k] && !cur[k] && e.base_code != e.layer_code) begin
                            send = 1'b1;
                            if (e.base_code != e.base_word) begin
                                if (fn_press)
                                    mod_state = (mod_state & ~e.base_code) | e.layer_code;
                                else
                                    mod_state = (mod_state & ~e.layer_code) | e.base_code;
                            end else if (fn_press) begin
                                slot_free(e.base_code);
                                slot_take(e.layer_word);
                            end else begin
                                slot_free(e.layer_word);
                                slot_take(e.base_word);
                            end
                        end
                    end
                end
            end

            if (!lock_on) begin
                for (int r = 0; r < MATRIX_ROWS_DEF; r++) begin
                    for (int c = 0; c < MATRIX_COLS_DEF; c++) begin
                        k    = r * 8 + c;
                        e    = layout_tbl[k];
                        code = fn_on ? e.layer_code : e.base_code;
                        rel  = cur[k];
                        if (prev[k] != rel) begin
                            send = 1'b1;
                            if (e.base_code != e.base_word) begin
                                if (rel) mod_state = mod_state & ~code;
                                else     mod_state = mod_state | code;
                            end else if (rel) begin
                                slot_free(code);
                            end else begin
                                slot_take(code);
                            end
                        end
                    end
                end
            end
        end

        prev_levels = cur;
        seen_scan   = 1'b1;

        if (send) begin
            rpt.modifier_byte = mod_state;
            rpt.slot_zero     = slots[0];
            rpt.slot_one      = slots[1];
            rpt.slot_two      = slots[2];
            rpt.slot_three    = slots[3];
            rpt.slot_four     = slots[4];
            rpt.slot_five     = slots[5];
            expected_reports.push_back(rpt);
        end
    endtask

    task automatic check_byte(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            prev_levels  = '1;
            mod_state    = 8'd0;
            for (int i = 0; i < MAX_SLOTS; i++) slots[i] = 8'd0;
            fn_on        = 1'b0;
            lock_on      = 1'b0;
            seen_scan    = 1'b0;
            fn_pos       = FN_POS_RESET;
            lock_pos     = LOCK_POS_RESET;
            expected_reports.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
            o_reports     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_FN_POS) fn_pos = i_pwdata[KEY_W-1:0];
                else                          lock_pos = i_pwdata[KEY_W-1:0];
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("report arrived with no report expected");
                    o_mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_byte("modifier_byte", want.modifier_byte,
                               i_out_data.modifier_byte);
                    check_byte("slot_zero",  want.slot_zero,  i_out_data.slot_zero);
                    check_byte("slot_one",   want.slot_one,   i_out_data.slot_one);
                    check_byte("slot_two",   want.slot_two,   i_out_data.slot_two);
                    check_byte("slot_three", want.slot_three, i_out_data.slot_three);
                    check_byte("slot_four",  want.slot_four,  i_out_data.slot_four);
                    check_byte("slot_five",  want.slot_five,  i_out_data.slot_five);
                    o_reports++;
                end
            end

            if (i_in_valid && !i_in_stall) predict_report(i_in_data);

            o_outstanding = expected_reports.size();
        end
    end

endmodule

@@ dv/keyboard_matrix_hid_report_builder_tb.sv @@
module keyboard_matrix_hid_report_builder_tb;
    import kmhrb_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    t_in_item               in_data;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_data;
    logic                   apb_sel;
    logic                   apb_enable;
    logic                   apb_write;
    logic [CFG_ADDR_W-1:0]  apb_addr;
    logic [CFG_DATA_W-1:0]  apb_wdata;
    logic [CFG_DATA_W-1:0]  apb_rdata;
    logic                   apb_ready;

    int                     mismatches;
    int                     outstanding;
    int                     reports;

    int                     send_idle = 0;
    int                     recv_stall = 0;
    int                     scans_sent = 0;
    int                     layouts_sent = 0;
    logic [KEY_W-1:0]       fn_at = FN_POS_RESET;
    logic [KEY_W-1:0]       lock_at = LOCK_POS_RESET;

    keyboard_matrix_hid_report_builder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (apb_sel),
        .penable     (apb_enable),
        .pwrite      (apb_write),
        .paddr       (apb_addr),
        .pwdata      (apb_wdata),
        .prdata      (apb_rdata),
        .pready      (apb_ready)
    );

    kmhrb_report_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_psel        (apb_sel),
        .i_penable     (apb_enable),
        .i_pwrite      (apb_write),
        .i_paddr       (apb_addr),
        .i_pwdata      (apb_wdata),
        .i_pready      (apb_ready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_reports     (reports)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    initial begin
        #30_000_000;
        $display("keyboard_matrix_hid_report_builder_tb NOT OK");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_item(input t_in_item req);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        if (req.operation == OP_SCAN) scans_sent++;
        else                          layouts_sent++;
        @(negedge clk);
    endtask

    task automatic write_layout(input int k, input logic [7:0] bc, input logic [7:0] lc,
                                input logic [7:0] bw, input logic [7:0] lw);
        t_in_item req;
        req.operation     = OP_LAYOUT;
        req.key_index     = k[5:0];
        req.base_code     = bc;
        req.layer_code    = lc;
        req.base_word     = bw;
        req.layer_word    = lw;
        req.matrix_levels = {$urandom, $urandom};
        push_item(req);
    endtask

    task automatic send_scan(input logic [63:0] levels);
        t_in_item req;
        req.operation     = OP_SCAN;
        req.key_index     = 6'($urandom);
        req.base_code     = 8'($urandom);
        req.layer_code    = 8'($urandom);
        req.base_word     = 8'($urandom);
        req.layer_word    = 8'($urandom);
        req.matrix_levels = levels;
        push_item(req);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [KEY_W-1:0] pos);
        apb_sel    = 1'b1;
        apb_enable = 1'b0;
        apb_write  = 1'b1;
        apb_addr   = addr;
        apb_wdata  = {{(CFG_DATA_W-KEY_W){1'b0}}, pos};
        @(negedge clk);
        apb_enable = 1'b1;
        forever begin
            @(posedge clk);
            if (apb_ready) break;
        end
        @(negedge clk);
        apb_sel    = 1'b0;
        apb_enable = 1'b0;
        apb_write  = 1'b0;
    endtask

    task automatic set_positions(input logic [KEY_W-1:0] fn, input logic [KEY_W-1:0] lock);
        reg_write({REG_FN_POS, 2'b00}, fn);
        reg_write({REG_LOCK_POS, 2'b00}, lock);
        fn_at   = fn;
        lock_at = lock;
    endtask

    // hold the sender until every report is out, then let a silent scan finish
    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (500) @(negedge clk);
    endtask

    initial begin
        logic [63:0]      lv;
        logic [7:0]       bc;
        logic [7:0]       lc;
        logic [7:0]       bw;
        logic [7:0]       lw;
        int               k;
        int               pick;
        logic [KEY_W-1:0] fn_list [6];
        logic [KEY_W-1:0] lock_list [6];
        int               stall_list [6];
        int               idle_list [6];

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        apb_sel    = 1'b0;
        apb_enable = 1'b0;
        apb_write  = 1'b0;
        apb_addr   = '0;
        apb_wdata  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        set_positions(6'd63, 6'd23);

        // fill the whole table before any scan reads it
        for (int i = 0; i < LAYOUT_DEPTH; i++) begin
            if (i % 8 == 6) begin
                bc = 8'd1 << (i / 8);
                lc = 8'd1 << ((i / 8 + 3) % 8);
                write_layout(i, bc, lc, ~bc, 8'($urandom));
            end else if (i % 8 == 7) begin
                write_layout(i, 8'(4 + i), 8'(4 + i), 8'(4 + i), 8'(8'h80 + i));
            end else begin
                write_layout(i, 8'(4 + i), 8'(8'h80 + i), 8'(4 + i), 8'(8'h80 + i));
            end
        end

        lv = '1;
        send_scan(lv);                          // first scan only records
        lv[0] = 1'b0;  send_scan(lv);
        lv[6] = 1'b0;  send_scan(lv);           // modifier down
        lv[1] = 1'b0; lv[2] = 1'b0; lv[3] = 1'b0; lv[4] = 1'b0;
        lv[8] = 1'b0; lv[9] = 1'b0;
        send_scan(lv);                          // more keys than slots
        lv[9] = 1'b1;  send_scan(lv);           // release of a dropped code
        lv[1] = 1'b1;  send_scan(lv);
        lv[fn_at] = 1'b0;  send_scan(lv);       // fn swaps held keys
        lv[10] = 1'b0; send_scan(lv);
        lv[fn_at] = 1'b1;  send_scan(lv);
        lv[lock_at] = 1'b0; send_scan(lv);      // lock clears everything
        lv[12] = 1'b0; lv[0] = 1'b1; send_scan(lv);
        lv[fn_at] = 1'b0;  send_scan(lv);       // fn still acts while locked
        lv[fn_at] = 1'b1;  send_scan(lv);
        lv[lock_at] = 1'b1; send_scan(lv);
        send_scan('0);
        send_scan('1);
        send_scan(~(64'd1 << lock_at));
        lv = '1;
        send_scan(lv);

        fn_list    = '{6'd63, 6'd0, 6'd63, 6'd17, 6'($urandom), 6'($urandom)};
        lock_list  = '{6'd23, 6'd63, 6'd0, 6'd17, 6'($urandom), 6'($urandom)};
        idle_list  = '{0, 82, 0, 7, 0, 0};
        stall_list = '{0, 0, 82, 7, 0, 82};

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            set_positions(fn_list[ph], lock_list[ph]);
            send_idle  = idle_list[ph];
            recv_stall = stall_list[ph];
            for (int n = 0; n < 145; n++) begin
                if (n == 72) drain();
                pick = $urandom_range(99);
                if (pick < 15) begin
                    k = $urandom_range(63);
                    case ($urandom_range(9))
                        0, 1, 2, 3: begin
                            bc = 8'($urandom);
                            lc = ($urandom_range(3) == 0) ? bc : 8'($urandom);
                            write_layout(k, bc, lc, bc,
                                         $urandom_range(1) ? lc : 8'($urandom));
                        end
                        4, 5, 6: begin
                            bc = 8'd1 << $urandom_range(7);
                            lc = 8'd1 << $urandom_range(7);
                            write_layout(k, bc, lc, bc ^ 8'($urandom_range(1, 255)),
                                         8'($urandom));
                        end
                        default: write_layout(k, 8'($urandom), 8'($urandom),
                                              8'($urandom), 8'($urandom));
                    endcase
                end else if (pick < 20) begin
                    lv = {$urandom, $urandom};
                    send_scan(lv);
                end else begin
                    // a few presses and releases, keeping the held count modest
                    repeat ($urandom_range(1, 3)) begin
                        k = $urandom_range(63);
                        if (lv[k] && $countones(~lv) >= 9) begin
                            do k = $urandom_range(63); while (lv[k]);
                        end
                        lv[k] = ~lv[k];
                    end
                    if ($urandom_range(99) < 10) lv[fn_at] = ~lv[fn_at];
                    if ($urandom_range(99) < 6)  lv[lock_at] = ~lv[lock_at];
                    send_scan(lv);
                end
            end
        end

        drain();
        $display("covered %0d scans and %0d layout writes over 6 key position settings",
                 scans_sent, layouts_sent);
        $display("and 4 idle patterns, with %0d reports compared", reports);
        if (mismatches == 0) begin
            $display("keyboard_matrix_hid_report_builder_tb OK");
        end else begin
            $display("keyboard_matrix_hid_report_builder_tb NOT OK");
        end
        $finish;
    end

endmodule
